// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the lowest common ancestor query engine.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TPL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tpl assertion failed");
`define TPL_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tpl forbidden condition seen");
`else
`define TPL_ASSERT(lbl, clk, rst_n, prop)
`define TPL_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/tpl_pkg.sv =====
// Package of the lowest common ancestor query engine: widths, codes, the
// controller-to-datapath command and status types and the saturating adder.
// Depends on nothing.
`timescale 1ns / 1ps

package tpl_pkg;

    localparam int NODE_W      = 16;
    localparam int NODES       = 1 << NODE_W;
    localparam int LEVELS      = 16;
    localparam int LVL_W       = $clog2(LEVELS);
    localparam int ADDR_W      = NODE_W + LVL_W;
    localparam int WEIGHT_BITS = 20;
    localparam int EDGE_W      = 20;
    localparam int COST_W      = 36;
    localparam int DEPTH_W     = 16;
    localparam int ACT_W       = 2;
    localparam int POS_W       = 16;
    localparam int OP_W        = 5;

    localparam logic [COST_W-1:0]  COST_MAX  = '1;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_COST = 2'd1;
    localparam logic [ACT_W-1:0] ACT_NODE = 2'd2;

    // Datapath operations, one per cycle.
    localparam logic [OP_W-1:0] OP_IDLE     = 5'd0;
    localparam logic [OP_W-1:0] OP_CAPTURE  = 5'd1;
    localparam logic [OP_W-1:0] OP_LD_DEPTH = 5'd2;
    localparam logic [OP_W-1:0] OP_LD_ROW0  = 5'd3;
    localparam logic [OP_W-1:0] OP_LD_RD    = 5'd4;
    localparam logic [OP_W-1:0] OP_LD_WR    = 5'd5;
    localparam logic [OP_W-1:0] OP_RD_DU    = 5'd6;
    localparam logic [OP_W-1:0] OP_RD_DV    = 5'd7;
    localparam logic [OP_W-1:0] OP_SWAP     = 5'd8;
    localparam logic [OP_W-1:0] OP_UP_RD    = 5'd9;
    localparam logic [OP_W-1:0] OP_UP_UPD   = 5'd10;
    localparam logic [OP_W-1:0] OP_LCA_EQ   = 5'd11;
    localparam logic [OP_W-1:0] OP_PAIR_RD  = 5'd12;
    localparam logic [OP_W-1:0] OP_PAIR_UPD = 5'd13;
    localparam logic [OP_W-1:0] OP_FINAL    = 5'd14;
    localparam logic [OP_W-1:0] OP_RD_DL    = 5'd15;
    localparam logic [OP_W-1:0] OP_PLAN     = 5'd16;
    localparam logic [OP_W-1:0] OP_CL_RD    = 5'd17;
    localparam logic [OP_W-1:0] OP_CL_UPD   = 5'd18;
    localparam logic [OP_W-1:0] OP_OUT_COST = 5'd19;
    localparam logic [OP_W-1:0] OP_OUT_NODE = 5'd20;
    localparam logic [OP_W-1:0] OP_OUT_ERR  = 5'd21;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [LVL_W-1:0] lvl;
    } tpl_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             load_bad;
        logic             query_bad;
        logic             nodes_eq;
        logic             pos_err;
    } tpl_sts_t;

    // Sum of three costs, clamped to the largest cost.
    function automatic logic [COST_W-1:0] sat_add3(
        input logic [COST_W-1:0] a,
        input logic [COST_W-1:0] b,
        input logic [COST_W-1:0] c
    );
        logic [COST_W+1:0] s;
        s = (COST_W+2)'(a) + (COST_W+2)'(b) + (COST_W+2)'(c);
        if (s > (COST_W+2)'(COST_MAX))
            return COST_MAX;
        return s[COST_W-1:0];
    endfunction

endpackage

// ===== rtl/core/tpl_if.sv =====
// Handshake channels of the lowest common ancestor query engine: request,
// response and configuration write. Depends on tpl_pkg.
`timescale 1ns / 1ps

interface tpl_req_if;
    logic                           valid;
    logic                           ready;
    logic [tpl_pkg::ACT_W-1:0]      action;
    logic [tpl_pkg::NODE_W-1:0]     node_a;
    logic [tpl_pkg::NODE_W-1:0]     node_b;
    logic [tpl_pkg::EDGE_W-1:0]     edge_weight;
    logic [tpl_pkg::POS_W-1:0]      position_k;

    modport source (output valid, action, node_a, node_b, edge_weight, position_k,
                    input ready);
    modport sink (input valid, action, node_a, node_b, edge_weight, position_k,
                  output ready);
endinterface

interface tpl_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [tpl_pkg::COST_W-1:0]     path_cost;
    logic [tpl_pkg::NODE_W-1:0]     node_id;
    logic                           status;

    modport source (output valid, path_cost, node_id, status, input ready);
    modport sink (input valid, path_cost, node_id, status, output ready);
endinterface

interface tpl_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tpl_pkg::NODE_W-1:0]     node_count;

    modport source (output valid, node_count, input ready);
    modport sink (input valid, node_count, output ready);
endinterface

// ===== rtl/core/tpl_datapath.sv =====
// Datapath of the query engine: lifting tables, depth table, walker
// registers and result registers. Depends on tpl_pkg.
`timescale 1ns / 1ps

module tpl_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tpl_pkg::tpl_cmd_t           cmd,
    output tpl_pkg::tpl_sts_t           sts,
    input  logic [tpl_pkg::ACT_W-1:0]   action,
    input  logic [tpl_pkg::NODE_W-1:0]  node_a,
    input  logic [tpl_pkg::NODE_W-1:0]  node_b,
    input  logic [tpl_pkg::EDGE_W-1:0]  edge_weight,
    input  logic [tpl_pkg::POS_W-1:0]   position_k,
    input  logic                        cfg_valid,
    input  logic [tpl_pkg::NODE_W-1:0]  cfg_data,
    output logic                        cfg_ready,
    output logic [tpl_pkg::COST_W-1:0]  path_cost,
    output logic [tpl_pkg::NODE_W-1:0]  node_id,
    output logic                        status
);
    import tpl_pkg::*;

    localparam int SW = DEPTH_W + 3;
    localparam int MEM_DEPTH = NODES * LEVELS;

    logic [NODE_W-1:0]  anc_mem   [0:MEM_DEPTH-1];
    logic [COST_W-1:0]  cost_mem  [0:MEM_DEPTH-1];
    logic [DEPTH_W-1:0] depth_mem [0:NODES-1];

    logic [ACT_W-1:0]   action_reg;
    logic [NODE_W-1:0]  u_reg, v_reg, a_reg, b_reg, lca_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic [POS_W-1:0]   k_reg;
    logic [DEPTH_W-1:0] du_reg, dv_reg, diff_reg, steps_reg;
    logic [COST_W-1:0]  sum_reg;
    logic               load_bad_reg, query_bad_reg, pos_err_reg;
    logic [NODE_W-1:0]  node_count_reg;
    logic [COST_W-1:0]  path_cost_reg;
    logic [NODE_W-1:0]  node_id_reg;
    logic               status_reg;

    logic [NODE_W-1:0]  anc_rd_a_reg, anc_rd_b_reg;
    logic [COST_W-1:0]  cost_rd_a_reg, cost_rd_b_reg;
    logic [DEPTH_W-1:0] depth_rd_reg;
    logic               zero_a_reg, zero_b_reg, zero_d_reg;

    logic [LVL_W-1:0]   rd_lvl_a;
    logic [ADDR_W-1:0]  rd_addr_a, rd_addr_b, wr_addr;
    logic [NODE_W-1:0]  depth_rd_node;
    logic               row_we;
    logic [NODE_W-1:0]  wr_anc;
    logic [COST_W-1:0]  wr_cost;
    logic [NODE_W-1:0]  anc_a, anc_b;
    logic [COST_W-1:0]  cost_a, cost_b, cost_w;
    logic [DEPTH_W-1:0] depth_eff, depth_new;

    logic signed [SW-1:0] du_s, dv_s, dl_s, len_s, ord_s, up_s, back_s;
    logic                 plan_err, plan_up;

    // The null node reads as an all-zero row without ever being written.
    assign anc_a     = zero_a_reg ? '0 : anc_rd_a_reg;
    assign anc_b     = zero_b_reg ? '0 : anc_rd_b_reg;
    assign cost_a    = zero_a_reg ? '0 : cost_rd_a_reg;
    assign cost_b    = zero_b_reg ? '0 : cost_rd_b_reg;
    assign depth_eff = zero_d_reg ? '0 : depth_rd_reg;
    assign cost_w    = COST_W'(w_reg);

    assign rd_lvl_a  = (cmd.op == OP_LD_RD) ? cmd.lvl - LVL_W'(1) : cmd.lvl;
    assign rd_addr_a = {a_reg, rd_lvl_a};
    assign rd_addr_b = {b_reg, cmd.lvl};

    always_comb
    begin
        case (cmd.op)
            OP_RD_DU: depth_rd_node = u_reg;
            OP_RD_DV: depth_rd_node = v_reg;
            OP_RD_DL: depth_rd_node = lca_reg;
            default:  depth_rd_node = v_reg;
        endcase
    end

    always_comb
    begin
        row_we  = 1'b0;
        wr_addr = {u_reg, cmd.lvl};
        wr_anc  = anc_a;
        wr_cost = sat_add3(sum_reg, cost_a, '0);
        if (cmd.op == OP_LD_ROW0)
        begin
            row_we  = 1'b1;
            wr_addr = {u_reg, LVL_W'(0)};
            wr_anc  = v_reg;
            wr_cost = cost_w;
        end
        else if (cmd.op == OP_LD_WR)
        begin
            row_we = 1'b1;
        end
    end

    always_comb
    begin
        if (v_reg == '0)
            depth_new = '0;
        else if (depth_eff == DEPTH_MAX)
            depth_new = DEPTH_MAX;
        else
            depth_new = depth_eff + DEPTH_W'(1);
    end

    // Position planning: path length and which side the k-th node sits on.
    assign du_s    = signed'(SW'(du_reg));
    assign dv_s    = signed'(SW'(dv_reg));
    assign dl_s    = signed'(SW'(depth_eff));
    assign len_s   = du_s + dv_s - (dl_s <<< 1);
    assign ord_s   = signed'(SW'(k_reg)) - SW'(1);
    assign up_s    = du_s - dl_s;
    assign back_s  = len_s - ord_s;
    assign plan_err = (k_reg == '0) || (len_s < 0) || (ord_s > len_s);
    assign plan_up  = (ord_s <= up_s);

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            anc_mem[wr_addr]  <= wr_anc;
            cost_mem[wr_addr] <= wr_cost;
        end
        anc_rd_a_reg  <= anc_mem[rd_addr_a];
        cost_rd_a_reg <= cost_mem[rd_addr_a];
        anc_rd_b_reg  <= anc_mem[rd_addr_b];
        cost_rd_b_reg <= cost_mem[rd_addr_b];
        zero_a_reg    <= (a_reg == '0);
        zero_b_reg    <= (b_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LD_ROW0)
            depth_mem[u_reg] <= depth_new;
        depth_rd_reg <= depth_mem[depth_rd_node];
        zero_d_reg   <= (depth_rd_node == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_count_reg <= NODE_W'(1);
        else if (cfg_valid)
            node_count_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                action_reg    <= action;
                u_reg         <= node_a;
                v_reg         <= node_b;
                w_reg         <= edge_weight[WEIGHT_BITS-1:0];
                k_reg         <= position_k;
                load_bad_reg  <= (node_a == '0);
                query_bad_reg <= (node_a == '0) || (node_a > node_count_reg) ||
                                 (node_b == '0) || (node_b > node_count_reg);
            end
            OP_LD_ROW0:
            begin
                a_reg   <= v_reg;
                sum_reg <= cost_w;
            end
            OP_LD_WR:
            begin
                a_reg   <= anc_a;
                sum_reg <= wr_cost;
            end
            OP_RD_DV:
            begin
                du_reg <= depth_eff;
            end
            OP_SWAP:
            begin
                dv_reg  <= depth_eff;
                sum_reg <= '0;
                if (depth_eff > du_reg)
                begin
                    a_reg    <= v_reg;
                    b_reg    <= u_reg;
                    diff_reg <= depth_eff - du_reg;
                end
                else
                begin
                    a_reg    <= u_reg;
                    b_reg    <= v_reg;
                    diff_reg <= du_reg - depth_eff;
                end
            end
            OP_UP_UPD:
            begin
                if (diff_reg[cmd.lvl])
                begin
                    sum_reg <= sat_add3(sum_reg, cost_a, '0);
                    a_reg   <= anc_a;
                end
            end
            OP_LCA_EQ:
            begin
                lca_reg <= a_reg;
            end
            OP_PAIR_UPD:
            begin
                if (anc_a != anc_b)
                begin
                    sum_reg <= sat_add3(sum_reg, cost_a, cost_b);
                    a_reg   <= anc_a;
                    b_reg   <= anc_b;
                end
            end
            OP_FINAL:
            begin
                sum_reg <= sat_add3(sum_reg, cost_a, cost_b);
                lca_reg <= anc_a;
            end
            OP_PLAN:
            begin
                pos_err_reg <= plan_err;
                a_reg       <= plan_up ? u_reg : v_reg;
                steps_reg   <= plan_up ? ord_s[DEPTH_W-1:0] : back_s[DEPTH_W-1:0];
            end
            OP_CL_UPD:
            begin
                if (steps_reg[cmd.lvl])
                    a_reg <= anc_a;
            end
            OP_OUT_COST:
            begin
                path_cost_reg <= sum_reg;
                node_id_reg   <= '0;
                status_reg    <= 1'b0;
            end
            OP_OUT_NODE:
            begin
                path_cost_reg <= '0;
                node_id_reg   <= a_reg;
                status_reg    <= 1'b0;
            end
            OP_OUT_ERR:
            begin
                path_cost_reg <= '0;
                node_id_reg   <= '0;
                status_reg    <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign sts.action    = action_reg;
    assign sts.load_bad  = load_bad_reg;
    assign sts.query_bad = query_bad_reg;
    assign sts.nodes_eq  = (a_reg == b_reg);
    assign sts.pos_err   = pos_err_reg;

    assign cfg_ready = 1'b1;
    assign path_cost = path_cost_reg;
    assign node_id   = node_id_reg;
    assign status    = status_reg;

endmodule

// ===== rtl/core/tpl_ctrl.sv =====
// Controller of the query engine: sequences loads and queries level by
// level and owns the handshakes. Depends on tpl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  tpl_pkg::tpl_sts_t  sts,
    output tpl_pkg::tpl_cmd_t  cmd
);
    import tpl_pkg::*;

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_DECODE   = 5'd1;
    localparam logic [4:0] ST_LD_DEP   = 5'd2;
    localparam logic [4:0] ST_LD_ROW0  = 5'd3;
    localparam logic [4:0] ST_LD_RD    = 5'd4;
    localparam logic [4:0] ST_LD_WR    = 5'd5;
    localparam logic [4:0] ST_Q_DU     = 5'd6;
    localparam logic [4:0] ST_Q_DV     = 5'd7;
    localparam logic [4:0] ST_SWAP     = 5'd8;
    localparam logic [4:0] ST_UP_RD    = 5'd9;
    localparam logic [4:0] ST_UP_UPD   = 5'd10;
    localparam logic [4:0] ST_CHECK    = 5'd11;
    localparam logic [4:0] ST_PAIR_RD  = 5'd12;
    localparam logic [4:0] ST_PAIR_UPD = 5'd13;
    localparam logic [4:0] ST_FIN_RD   = 5'd14;
    localparam logic [4:0] ST_FIN      = 5'd15;
    localparam logic [4:0] ST_RD_DL    = 5'd16;
    localparam logic [4:0] ST_PLAN     = 5'd17;
    localparam logic [4:0] ST_DECIDE   = 5'd18;
    localparam logic [4:0] ST_CL_RD    = 5'd19;
    localparam logic [4:0] ST_CL_UPD   = 5'd20;
    localparam logic [4:0] ST_OUT_COST = 5'd21;
    localparam logic [4:0] ST_OUT_NODE = 5'd22;
    localparam logic [4:0] ST_OUT_ERR  = 5'd23;

    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);

    logic [4:0]       state_reg, state_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        out_valid_next = out_valid_reg && !out_ready;
        req_ready      = 1'b0;
        cmd.op         = OP_IDLE;
        cmd.lvl        = lvl_reg;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.action)
                    ACT_LOAD: state_next = sts.load_bad ? ST_IDLE : ST_LD_DEP;
                    ACT_COST, ACT_NODE:
                        state_next = sts.query_bad ? ST_OUT_ERR : ST_Q_DU;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_LD_DEP:
            begin
                cmd.op     = OP_LD_DEPTH;
                state_next = ST_LD_ROW0;
            end
            ST_LD_ROW0:
            begin
                cmd.op     = OP_LD_ROW0;
                lvl_next   = LVL_W'(1);
                state_next = ST_LD_RD;
            end
            ST_LD_RD:
            begin
                cmd.op     = OP_LD_RD;
                state_next = ST_LD_WR;
            end
            ST_LD_WR:
            begin
                cmd.op = OP_LD_WR;
                if (lvl_reg == LVL_TOP)
                    state_next = ST_IDLE;
                else
                begin
                    lvl_next   = lvl_reg + LVL_W'(1);
                    state_next = ST_LD_RD;
                end
            end
            ST_Q_DU:
            begin
                cmd.op     = OP_RD_DU;
                state_next = ST_Q_DV;
            end
            ST_Q_DV:
            begin
                cmd.op     = OP_RD_DV;
                state_next = ST_SWAP;
            end
            ST_SWAP:
            begin
                cmd.op     = OP_SWAP;
                lvl_next   = LVL_TOP;
                state_next = ST_UP_RD;
            end
            ST_UP_RD:
            begin
                cmd.op     = OP_UP_RD;
                state_next = ST_UP_UPD;
            end
            ST_UP_UPD:
            begin
                cmd.op = OP_UP_UPD;
                if (lvl_reg == '0)
                    state_next = ST_CHECK;
                else
                begin
                    lvl_next   = lvl_reg - LVL_W'(1);
                    state_next = ST_UP_RD;
                end
            end
            ST_CHECK:
            begin
                cmd.op = OP_LCA_EQ;
                if (sts.nodes_eq)
                    state_next = (sts.action == ACT_COST) ? ST_OUT_COST : ST_RD_DL;
                else
                begin
                    lvl_next   = LVL_TOP;
                    state_next = ST_PAIR_RD;
                end
            end
            ST_PAIR_RD:
            begin
                cmd.op     = OP_PAIR_RD;
                state_next = ST_PAIR_UPD;
            end
            ST_PAIR_UPD:
            begin
                cmd.op = OP_PAIR_UPD;
                if (lvl_reg == '0)
                    state_next = ST_FIN_RD;
                else
                begin
                    lvl_next   = lvl_reg - LVL_W'(1);
                    state_next = ST_PAIR_RD;
                end
            end
            ST_FIN_RD:
            begin
                cmd.op     = OP_PAIR_RD;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.op     = OP_FINAL;
                state_next = (sts.action == ACT_COST) ? ST_OUT_COST : ST_RD_DL;
            end
            ST_RD_DL:
            begin
                cmd.op     = OP_RD_DL;
                state_next = ST_PLAN;
            end
            ST_PLAN:
            begin
                cmd.op     = OP_PLAN;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (sts.pos_err)
                    state_next = ST_OUT_ERR;
                else
                begin
                    lvl_next   = LVL_TOP;
                    state_next = ST_CL_RD;
                end
            end
            ST_CL_RD:
            begin
                cmd.op     = OP_CL_RD;
                state_next = ST_CL_UPD;
            end
            ST_CL_UPD:
            begin
                cmd.op = OP_CL_UPD;
                if (lvl_reg == '0)
                    state_next = ST_OUT_NODE;
                else
                begin
                    lvl_next   = lvl_reg - LVL_W'(1);
                    state_next = ST_CL_RD;
                end
            end
            ST_OUT_COST, ST_OUT_NODE, ST_OUT_ERR:
            begin
                if (slot_free)
                begin
                    case (state_reg)
                        ST_OUT_COST: cmd.op = OP_OUT_COST;
                        ST_OUT_NODE: cmd.op = OP_OUT_NODE;
                        default:     cmd.op = OP_OUT_ERR;
                    endcase
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lvl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `TPL_ASSERT(a_rise_from_emit, clk, rst_n, $rose(out_valid_reg) |-> ($past(state_reg) == ST_OUT_COST || $past(state_reg) == ST_OUT_NODE || $past(state_reg) == ST_OUT_ERR))
    `TPL_ASSERT(a_accept_decodes, clk, rst_n, (req_valid && req_ready) |=> (state_reg == ST_DECODE))
    `TPL_ASSERT(a_climb_ends_check, clk, rst_n, (state_reg == ST_UP_UPD && lvl_reg == '0) |=> (state_reg == ST_CHECK))
    `TPL_ASSERT_NEVER(a_no_overwrite, clk, rst_n, (cmd.op == OP_OUT_COST || cmd.op == OP_OUT_NODE || cmd.op == OP_OUT_ERR) && out_valid_reg && !out_ready)

endmodule

// ===== rtl/core/tree_path_lca_query.sv =====
// Top level of the weighted-tree lowest common ancestor query engine.
// Depends on tpl_pkg, tpl_if, tpl_ctrl and tpl_datapath.
`timescale 1ns / 1ps
//
//   channel  role   carries
//   -------  -----  ------------------------------------------------------
//   req      sink   action, node_a, node_b, edge_weight, position_k
//   rsp      source path_cost, node_id, status (one item per query)
//   cfg      sink   node_count (highest id a query may name)
//
// A load reads the parent's depth, writes row 0 and the node's depth, then for
// each of the fifteen upper lifting levels reads the middle ancestor and
// writes the row. A cost query and a position query each walk the sixteen
// levels in passes; at each level they do a registered table read and then
// update the walker.
// Reset clears only the controller and node_count (to 1); table rows of the
// null node read as zero by address compare, so no clearing pass is needed.
// A new request is taken while an earlier result waits on rsp; the engine only
// stalls at the point of writing its next result into the occupied register.

module tree_path_lca_query (
    input  logic        clk,
    input  logic        rst_n,
    tpl_req_if.sink     req,
    tpl_rsp_if.source   rsp,
    tpl_cfg_if.sink     cfg
);
    import tpl_pkg::*;

    // Command and status between the sequencer and the datapath.
    tpl_cmd_t cmd;
    tpl_sts_t sts;
    logic     req_ready;
    logic     rsp_valid;
    logic     cfg_ready;

    tpl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .out_valid (rsp_valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath captures request fields only on the accepting cycle, so it
    // sees the payload lines directly.
    tpl_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .action      (req.action),
        .node_a      (req.node_a),
        .node_b      (req.node_b),
        .edge_weight (req.edge_weight),
        .position_k  (req.position_k),
        .cfg_valid   (cfg.valid),
        .cfg_data    (cfg.node_count),
        .cfg_ready   (cfg_ready),
        .path_cost   (rsp.path_cost),
        .node_id     (rsp.node_id),
        .status      (rsp.status)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;
    assign cfg.ready = cfg_ready;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the lowest common ancestor query engine.
// Depends on tpl_pkg, the tpl_if channels and the tree_path_lca_query top level.
`timescale 1ns / 1ps

module testbench;
    import tpl_pkg::*;

    // Action code that the engine must ignore without a response.
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
    // Idle cycles after which the run is declared hung.
    localparam int STALL_LIMIT = 20000;
    // Quiet cycles before a register write, covering a load still in flight.
    localparam int SETTLE_CYCLES = 150;

    typedef struct {
        logic [COST_W-1:0] cost;
        logic [NODE_W-1:0] id;
        logic              st;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tpl_req_if req_ch ();
    tpl_rsp_if rsp_ch ();
    tpl_cfg_if cfg_ch ();

    tree_path_lca_query u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #2 clk = ~clk;

    // Shadow copy of the engine tables. Rows of nodes never loaded read as
    // zero, which also gives the null node its all-zero row.
    logic [NODE_W-1:0]  anc_shadow [int];
    logic [COST_W-1:0]  cost_shadow [int];
    logic [DEPTH_W-1:0] depth_shadow [int];
    logic [NODE_W-1:0]  count_shadow;

    // Answers still owed by the engine, oldest first.
    answer_t owed_answers [$];
    // Nodes loaded so far, and those a query may legally name.
    logic [NODE_W-1:0] loaded_ids [$];
    logic [NODE_W-1:0] legal_ids [$];

    int errors = 0;
    int idle_cycles = 0;

    // Sender burst state: items left in the current burst.
    int burst_left = 0;

    function automatic logic [NODE_W-1:0] anc_of(logic [NODE_W-1:0] n, int lvl);
        int key;
        key = int'(n) * LEVELS + lvl;
        return anc_shadow.exists(key) ? anc_shadow[key] : '0;
    endfunction

    function automatic logic [COST_W-1:0] lift_of(logic [NODE_W-1:0] n, int lvl);
        int key;
        key = int'(n) * LEVELS + lvl;
        return cost_shadow.exists(key) ? cost_shadow[key] : '0;
    endfunction

    function automatic int depth_of(logic [NODE_W-1:0] n);
        return depth_shadow.exists(int'(n)) ? int'(depth_shadow[int'(n)]) : 0;
    endfunction

    function automatic logic [COST_W-1:0] cost_add(logic [COST_W-1:0] x,
                                                   logic [COST_W-1:0] y);
        logic [COST_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return (s > {1'b0, COST_MAX}) ? COST_MAX : s[COST_W-1:0];
    endfunction

    // Walks a node up by a number of levels, largest jumps first.
    function automatic logic [NODE_W-1:0] walk_up(logic [NODE_W-1:0] n, int steps);
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (steps >= (1 << i))
            begin
                n = anc_of(n, i);
                steps -= (1 << i);
            end
        end
        return n;
    endfunction

    // Meeting point of two nodes, with the summed weight of the path between.
    function automatic logic [NODE_W-1:0] meeting_node(logic [NODE_W-1:0] a,
                                                       logic [NODE_W-1:0] b,
                                                       output logic [COST_W-1:0] sum);
        logic [NODE_W-1:0] t;
        logic [NODE_W-1:0] pa;
        logic [NODE_W-1:0] pb;
        int diff;
        sum = '0;
        if (depth_of(b) > depth_of(a))
        begin
            t = a;
            a = b;
            b = t;
        end
        diff = depth_of(a) - depth_of(b);
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (diff >= (1 << i))
            begin
                sum = cost_add(sum, lift_of(a, i));
                a = anc_of(a, i);
                diff -= (1 << i);
            end
        end
        if (a == b)
            return a;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            pa = anc_of(a, i);
            pb = anc_of(b, i);
            if (pa != pb)
            begin
                sum = cost_add(sum, lift_of(a, i));
                sum = cost_add(sum, lift_of(b, i));
                a = pa;
                b = pb;
            end
        end
        sum = cost_add(sum, lift_of(a, 0));
        sum = cost_add(sum, lift_of(b, 0));
        return anc_of(a, 0);
    endfunction

    function automatic bit id_legal(logic [NODE_W-1:0] n);
        return n != 0 && n <= count_shadow;
    endfunction

    // Applies one accepted item to the shadow tables and queues its answer.
    function automatic void track_item(logic [ACT_W-1:0] act, logic [NODE_W-1:0] a,
                                       logic [NODE_W-1:0] b, logic [EDGE_W-1:0] w,
                                       logic [POS_W-1:0] k);
        answer_t ans;
        logic [NODE_W-1:0] mid;
        logic [NODE_W-1:0] lca;
        logic [COST_W-1:0] sum;
        int d;
        int du;
        int dv;
        int dl;
        int len;
        int ord;
        if (act == ACT_SPARE)
            return;
        if (act == ACT_LOAD)
        begin
            // A load of the null node is dropped.
            if (a == 0)
                return;
            d = (b != 0) ? depth_of(b) + 1 : 0;
            if (d > int'(DEPTH_MAX))
                d = int'(DEPTH_MAX);
            depth_shadow[int'(a)] = DEPTH_W'(d);
            anc_shadow[int'(a) * LEVELS] = b;
            cost_shadow[int'(a) * LEVELS] = COST_W'(w & ((1 << WEIGHT_BITS) - 1));
            for (int i = 1; i < LEVELS; i++)
            begin
                mid = anc_of(a, i - 1);
                anc_shadow[int'(a) * LEVELS + i] = anc_of(mid, i - 1);
                cost_shadow[int'(a) * LEVELS + i] =
                    cost_add(lift_of(a, i - 1), lift_of(mid, i - 1));
            end
            return;
        end
        ans.cost = '0;
        ans.id = '0;
        ans.st = 1'b1;
        if (id_legal(a) && id_legal(b))
        begin
            lca = meeting_node(a, b, sum);
            if (act == ACT_COST)
            begin
                ans.cost = sum;
                ans.st = 1'b0;
            end
            else
            begin
                du = depth_of(a);
                dv = depth_of(b);
                dl = depth_of(lca);
                len = du + dv - 2 * dl;
                ord = int'(k) - 1;
                if (!(k == 0 || len < 0 || ord > len))
                begin
                    ans.id = (ord <= du - dl) ? walk_up(a, ord) : walk_up(b, len - ord);
                    ans.st = 1'b0;
                end
            end
        end
        owed_answers.insert(owed_answers.size(), ans);
    endfunction

    // Sends one item; the sender keeps valid high within a burst and may idle
    // for a random gap once the burst runs out.
    task automatic send_item(logic [ACT_W-1:0] act, logic [NODE_W-1:0] a,
                             logic [NODE_W-1:0] b, logic [EDGE_W-1:0] w,
                             logic [POS_W-1:0] k);
        req_ch.valid <= 1'b1;
        req_ch.action <= act;
        req_ch.node_a <= a;
        req_ch.node_b <= b;
        req_ch.edge_weight <= w;
        req_ch.position_k <= k;
        do
            @(posedge clk);
        while (!req_ch.ready);
        track_item(act, a, b, w, k);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            // Valid only drops when a gap really follows, so it never gets
            // two assignments in the same step.
            if ($urandom_range(0, 2) != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    endtask

    // Drops valid, waits out every owed answer and any load still running.
    task automatic drain();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (owed_answers.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes node_count while the engine is idle and refreshes the legal ids.
    task automatic write_node_count(logic [NODE_W-1:0] value);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.node_count <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        count_shadow = value;
        legal_ids.delete();
        foreach (loaded_ids[i])
            if (loaded_ids[i] <= value)
                legal_ids.insert(legal_ids.size(), loaded_ids[i]);
    endtask

    function automatic logic [EDGE_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0: return '0;
            1, 2: return '1;
            default: return EDGE_W'($urandom());
        endcase
    endfunction

    function automatic logic [NODE_W-1:0] pick_legal();
        return legal_ids[$urandom_range(0, legal_ids.size() - 1)];
    endfunction

    // An id that fails the range check: the null node or one above node_count.
    function automatic logic [NODE_W-1:0] pick_illegal();
        if (count_shadow == '1 || $urandom_range(0, 3) == 0)
            return '0;
        return NODE_W'($urandom_range(int'(count_shadow) + 1, 65535));
    endfunction

    // Loads a node under a known parent and records it; a fresh node inside
    // the current range may be named by queries right away.
    task automatic load_node(logic [NODE_W-1:0] n, logic [NODE_W-1:0] parent,
                             logic [EDGE_W-1:0] w);
        if (!depth_shadow.exists(int'(n)))
        begin
            loaded_ids.insert(loaded_ids.size(), n);
            if (id_legal(n))
                legal_ids.insert(legal_ids.size(), n);
        end
        send_item(ACT_LOAD, n, parent, w, POS_W'($urandom()));
    endtask

    // Issues one query between two ids; the position is mostly near the path
    // length so both in-range and just-past-the-end positions come up.
    task automatic query_pair(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
        logic [POS_W-1:0] k;
        case ($urandom_range(0, 9))
            0: k = '0;
            1: k = POS_W'($urandom());
            default: k = POS_W'($urandom_range(1, depth_of(a) + depth_of(b) + 2));
        endcase
        send_item($urandom_range(0, 1) ? ACT_COST : ACT_NODE, a, b, pick_weight(), k);
    endtask

    // Directed checks: reset value of node_count, extreme ids and weights,
    // dropped loads, the unused action and the position bounds.
    task automatic test_directed();
        load_node(16'd1, 16'd0, '0);
        load_node(16'hFFFF, 16'd1, '1);
        load_node(16'd2, 16'hFFFF, 20'h5A5A5);
        send_item(ACT_LOAD, 16'd0, 16'd1, '1, 16'd1);
        send_item(ACT_SPARE, 16'd1, 16'd2, '1, 16'd1);
        // node_count is still 1 here: only node 1 may be named.
        send_item(ACT_COST, 16'd1, 16'd1, '0, 16'd1);
        send_item(ACT_NODE, 16'd1, 16'd1, '0, 16'd1);
        send_item(ACT_COST, 16'd1, 16'd2, '0, 16'd1);
        send_item(ACT_NODE, 16'hFFFF, 16'd1, '0, 16'd1);
        write_node_count('1);
        send_item(ACT_COST, 16'd2, 16'd1, '0, 16'd1);
        send_item(ACT_COST, 16'hFFFF, 16'd2, '0, 16'd1);
        send_item(ACT_COST, 16'd0, 16'd2, '0, 16'd1);
        send_item(ACT_NODE, 16'd2, 16'd1, '0, 16'd0);
        send_item(ACT_NODE, 16'd2, 16'd1, '0, 16'd1);
        send_item(ACT_NODE, 16'd2, 16'd1, '0, 16'd2);
        send_item(ACT_NODE, 16'd2, 16'd1, '0, 16'd3);
        send_item(ACT_NODE, 16'd2, 16'd1, '0, 16'd4);
        send_item(ACT_NODE, 16'd1, 16'd2, '0, 16'hFFFF);
        send_item(ACT_NODE, 16'd2, 16'd0, '0, 16'd1);
    endtask

    // Grows the tree with fresh random ids; mostly chains, so the upper
    // lifting levels get used, with the odd extra root making a forest.
    task automatic test_grow(int count);
        logic [NODE_W-1:0] n;
        logic [NODE_W-1:0] parent;
        repeat (count)
        begin
            do
                n = NODE_W'($urandom_range(1, 65535));
            while (depth_shadow.exists(int'(n)));
            case ($urandom_range(0, 19))
                0: parent = '0;
                1, 2, 3, 4: parent = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
                default: parent = loaded_ids[loaded_ids.size() - 1];
            endcase
            load_node(n, parent, pick_weight());
        end
    endtask

    // Random queries with a little noise: dropped loads, the unused action
    // and ids that fail the range check.
    task automatic test_queries(int count);
        repeat (count)
        begin
            case ($urandom_range(0, 19))
                0: send_item(ACT_LOAD, '0, NODE_W'($urandom()), pick_weight(),
                             POS_W'($urandom()));
                1: send_item(ACT_SPARE, NODE_W'($urandom()), NODE_W'($urandom()),
                             pick_weight(), POS_W'($urandom()));
                2: query_pair(pick_illegal(), pick_legal());
                3: query_pair(pick_legal(), pick_illegal());
                default: query_pair(pick_legal(), pick_legal());
            endcase
        end
    endtask

    // Reloads existing nodes under new parents; nodes below them keep their
    // stale rows, which the queries that follow must still agree with.
    task automatic test_reload(int count);
        logic [NODE_W-1:0] n;
        repeat (count)
        begin
            n = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
            load_node(n, loaded_ids[$urandom_range(0, loaded_ids.size() - 1)],
                      pick_weight());
            test_queries(4);
        end
    endtask

    // Result check: every accepted answer against the oldest owed one.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (owed_answers.size() == 0)
            begin
                $display("%0t: unexpected answer cost=%0d id=%0d status=%0d", $time,
                         rsp_ch.path_cost, rsp_ch.node_id, rsp_ch.status);
                errors++;
            end
            else
            begin
                if (rsp_ch.path_cost !== owed_answers[0].cost)
                begin
                    $display("%0t: path_cost expected %0d actual %0d", $time,
                             owed_answers[0].cost, rsp_ch.path_cost);
                    errors++;
                end
                if (rsp_ch.node_id !== owed_answers[0].id)
                begin
                    $display("%0t: node_id expected %0d actual %0d", $time,
                             owed_answers[0].id, rsp_ch.node_id);
                    errors++;
                end
                if (rsp_ch.status !== owed_answers[0].st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             owed_answers[0].st, rsp_ch.status);
                    errors++;
                end
                void'(owed_answers.pop_front());
            end
        end
    end

    // Receiver backpressure: the pattern is redrawn whenever its random countdown
    // runs out, among always ready, coin flips and long stalls.
    int rx_mode = 0;
    int rx_count = 0;
    always @(posedge clk)
    begin
        if (rx_count == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_count <= $urandom_range(100, 600);
        end
        else
            rx_count <= rx_count - 1;
        case (rx_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            2: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ch.ready <= ((rx_count % 24) < 4);
        endcase
    end

    // Hang detection: cycles without any accepted item on any channel.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.action = ACT_LOAD;
        req_ch.node_a = '0;
        req_ch.node_b = '0;
        req_ch.edge_weight = '0;
        req_ch.position_k = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.node_count = '0;
        rsp_ch.ready = 1'b0;
        count_shadow = 16'd1;
        legal_ids.insert(0, 16'd1);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_grow(220);
        test_queries(380);
        // Narrow the legal range to roughly half the loaded ids.
        write_node_count(NODE_W'($urandom_range(16'h4000, 16'hC000)));
        test_queries(250);
        test_reload(20);
        write_node_count(16'd1);
        test_queries(50);
        write_node_count('1);
        test_grow(60);
        test_queries(240);

        drain();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
